// ===== hw/rtl/smo_pkg.sv =====
package smo_pkg;

  localparam int XY_W     = 27;
  localparam int ACC_W    = 32;
  localparam int MUL_A_W  = 27;
  localparam int MUL_B_W  = 31;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int MAX_STEPS = 24;
  localparam int K_W      = 5;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 16;

  localparam logic [ADDR_W-1:0] REG_STATOR_RES  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_SLIDE_GAIN  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] REG_FILTER_GAIN = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] REG_CTRL_PERIOD = ADDR_W'(3);

  localparam logic signed [MUL_B_W-1:0] MAG_GAIN = 31'sd652032874;
  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] volt_alpha;
    logic signed [15:0] volt_beta;
    logic signed [15:0] amp_alpha;
    logic signed [15:0] amp_beta;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rotor_angle;
    logic [15:0]        emf_magnitude;
    logic signed [15:0] emf_alpha;
    logic signed [15:0] emf_beta;
  } out_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
  } cordic_t;

  function automatic logic [ACC_W-1:0] atan_turn(input logic [K_W-1:0] k);
    logic [ACC_W-1:0] a;
    unique case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051D;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2E;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/sliding_mode_backemf_observer_top.sv =====
// Sliding-mode back-EMF observer, one alpha/beta sample per control period.
// Input channel (in_valid/in_ready/in_data): voltages and currents, Q5.10.
// Output channel (out_valid/out_ready/out_data): rotor angle, back-EMF
// magnitude and the filtered alpha/beta back-EMF estimates.
// Config port: cfg_we/cfg_addr/cfg_wdata writes stator_resistance (0),
// slide_gain (1), filter_gain (2), control_period (3); other indexes ignored.
// Each sample steps through the residual, filter, CORDIC, magnitude and
// saturation states in order; the single shared multiplier serves both
// residuals, both filter updates and the magnitude scaling. The CORDIC runs
// one iteration per step of its iteration state. A zero back-EMF vector
// skips the CORDIC and magnitude states and goes straight to the output.
// in_ready is high only while the sequencer is idle.
// A finished result sits in the output register; if the receiver stalls,
// the sequencer holds its next result until that register is free.
// Synchronous reset clears the observer state and loads register defaults.
module sliding_mode_backemf_observer_top
  import smo_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0] cfg_wdata
);

  localparam int Steps = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam logic [K_W-1:0] LastK = K_W'(Steps - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RES_A = 4'd1;
  localparam logic [3:0] S_RES_B = 4'd2;
  localparam logic [3:0] S_FLT_A = 4'd3;
  localparam logic [3:0] S_FLT_B = 4'd4;
  localparam logic [3:0] S_FB    = 4'd5;
  localparam logic [3:0] S_INIT  = 4'd6;
  localparam logic [3:0] S_ITER  = 4'd7;
  localparam logic [3:0] S_MAG   = 4'd8;
  localparam logic [3:0] S_SAT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state;
  logic [15:0] stator_res;
  logic [14:0] slide_gain;
  logic [15:0] filter_gain;
  logic [15:0] ctrl_period;

  in_item_t           sample;
  logic signed [15:0] sw_a;
  logic signed [15:0] sw_b;
  logic signed [15:0] flt_a;
  logic signed [15:0] flt_b;
  cordic_t            cord;
  cordic_t            cord_next;
  logic [K_W-1:0]     k;
  logic [15:0]        res_angle;
  logic [15:0]        res_mag;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [15:0] cur_v;
  logic signed [15:0] cur_s;
  logic signed [17:0] vs_diff;
  logic signed [35:0] residual;
  logic signed [15:0] sw_pos;
  logic signed [15:0] sw_new;

  logic signed [15:0] cur_f;
  logic signed [35:0] flt_sum;
  logic signed [19:0] flt_raw;
  logic signed [15:0] flt_new;

  logic signed [PROD_W-1:0] mag_sum;
  logic signed [PROD_W-1:0] mag_raw;
  logic [15:0]              mag_sat;

  logic signed [XY_W-1:0] init_x;
  logic signed [XY_W-1:0] init_y;
  logic                   out_load;

  smo_cordic_step u_step (
    .cur (cord),
    .k   (k),
    .nxt (cord_next)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RES_A: begin
        mul_a = MUL_A_W'(sample.amp_alpha);
        mul_b = MUL_B_W'(signed'({1'b0, stator_res}));
      end
      S_RES_B: begin
        mul_a = MUL_A_W'(sample.amp_beta);
        mul_b = MUL_B_W'(signed'({1'b0, stator_res}));
      end
      S_FLT_A: begin
        mul_a = MUL_A_W'(17'(sw_a) - 17'(flt_a));
        mul_b = MUL_B_W'(signed'({1'b0, filter_gain}));
      end
      S_FLT_B: begin
        mul_a = MUL_A_W'(17'(sw_b) - 17'(flt_b));
        mul_b = MUL_B_W'(signed'({1'b0, filter_gain}));
      end
      S_MAG: begin
        mul_a = cord.x;
        mul_b = MAG_GAIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign cur_v    = (state == S_RES_B) ? sample.volt_alpha : sample.volt_beta;
  assign cur_s    = (state == S_RES_B) ? sw_a : sw_b;
  assign vs_diff  = 18'(cur_v) - 18'(cur_s);
  assign residual = (36'(vs_diff) <<< 12) - 36'(signed'(prod[33:0]));
  assign sw_pos   = signed'({1'b0, slide_gain});
  assign sw_new   = (ctrl_period != '0 && residual < 0) ? sw_pos : -sw_pos;

  assign cur_f   = (state == S_FLT_B) ? flt_a : flt_b;
  assign flt_sum = 36'(signed'(prod[33:0])) + 36'sd32768;
  assign flt_raw = 20'(cur_f) + 20'(flt_sum >>> 16);
  always_comb begin
    if (flt_raw > 20'sd32767) begin
      flt_new = 16'sh7FFF;
    end else if (flt_raw < -20'sd32768) begin
      flt_new = -16'sh8000;
    end else begin
      flt_new = 16'(flt_raw);
    end
  end

  assign mag_sum = prod + (PROD_W'(1) <<< 37);
  assign mag_raw = mag_sum >>> 38;
  always_comb begin
    if (mag_raw < 0) begin
      mag_sat = '0;
    end else if (mag_raw > PROD_W'(65535)) begin
      mag_sat = 16'hFFFF;
    end else begin
      mag_sat = 16'(mag_raw);
    end
  end

  assign init_x   = XY_W'(flt_b) <<< 8;
  assign init_y   = -(XY_W'(flt_a) <<< 8);
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      stator_res  <= 16'd2048;
      slide_gain  <= '0;
      filter_gain <= '0;
      ctrl_period <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STATOR_RES:  stator_res  <= cfg_wdata;
        REG_SLIDE_GAIN:  slide_gain  <= cfg_wdata[14:0];
        REG_FILTER_GAIN: filter_gain <= cfg_wdata;
        REG_CTRL_PERIOD: ctrl_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sw_a      <= '0;
      sw_b      <= '0;
      flt_a     <= '0;
      flt_b     <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample <= in_data;
            state  <= S_RES_A;
          end
        end
        S_RES_A: state <= S_RES_B;
        S_RES_B: begin
          sw_a  <= sw_new;
          state <= S_FLT_A;
        end
        S_FLT_A: begin
          sw_b  <= sw_new;
          state <= S_FLT_B;
        end
        S_FLT_B: begin
          flt_a <= flt_new;
          state <= S_FB;
        end
        S_FB: begin
          flt_b <= flt_new;
          state <= S_INIT;
        end
        S_INIT: begin
          k <= '0;
          if (flt_a == '0 && flt_b == '0) begin
            res_angle <= '0;
            res_mag   <= '0;
            state     <= S_OUT;
          end else begin
            if (init_x < 0) begin
              cord.x   <= -init_x;
              cord.y   <= -init_y;
              cord.acc <= HALF_TURN;
            end else begin
              cord.x   <= init_x;
              cord.y   <= init_y;
              cord.acc <= '0;
            end
            state <= S_ITER;
          end
        end
        S_ITER: begin
          cord <= cord_next;
          k    <= k + K_W'(1);
          if (k == LastK) begin
            state <= S_MAG;
          end
        end
        S_MAG: state <= S_SAT;
        S_SAT: begin
          res_angle <= 16'((cord.acc + 32'd32768) >> 16);
          res_mag   <= mag_sat;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.rotor_angle   <= signed'(res_angle);
      out_data.emf_magnitude <= res_mag;
      out_data.emf_alpha     <= flt_a;
      out_data.emf_beta      <= flt_b;
    end
  end

endmodule

// ===== hw/rtl/smo_cordic_step.sv =====
module smo_cordic_step
  import smo_pkg::*;
(
  input  cordic_t        cur,
  input  logic [K_W-1:0] k,
  output cordic_t        nxt
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic [ACC_W-1:0]       da;

  assign dx = cur.y >>> k;
  assign dy = cur.x >>> k;
  assign da = atan_turn(k);

  always_comb begin
    if (!cur.y[XY_W-1]) begin
      nxt.x   = cur.x + dx;
      nxt.y   = cur.y - dy;
      nxt.acc = cur.acc + da;
    end else begin
      nxt.x   = cur.x - dx;
      nxt.y   = cur.y + dy;
      nxt.acc = cur.acc - da;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import smo_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = CORDIC_STEPS + 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  sliding_mode_backemf_observer_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // register shadows and observer state
  logic [15:0]        rs_ohm = 16'd2048;
  logic [14:0]        slide_mag = '0;
  logic [15:0]        lp_gain = '0;
  logic [15:0]        ctrl_period = 16'd1;
  logic signed [15:0] sw_alpha = '0;
  logic signed [15:0] sw_beta = '0;
  logic signed [15:0] emf_a = '0;
  logic signed [15:0] emf_b = '0;

  in_item_t    sample_q[$];
  out_item_t   emf_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_src = 1'b0;
  bit          idle_sink = 1'b0;
  int unsigned stall_reqs = 0;
  int unsigned stall_seen = 0;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic signed [15:0] next_switch(logic signed [15:0] v,
                                                     logic signed [15:0] i,
                                                     logic signed [15:0] prev);
    longint resid;
    logic signed [15:0] g;
    resid = longint'(v) * 4096 - longint'(rs_ohm) * longint'(i) - longint'(prev) * 4096;
    g = $signed({1'b0, slide_mag});
    if (ctrl_period != 16'd0 && resid < 0) return g;
    return -g;
  endfunction

  function automatic logic signed [15:0] filter_step(logic signed [15:0] f,
                                                     logic signed [15:0] s);
    longint d;
    longint n;
    d = longint'(s) - longint'(f);
    n = longint'(f) + ((longint'(lp_gain) * d + 32768) >>> 16);
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n[15:0];
  endfunction

  function automatic out_item_t advance_observer(in_item_t s);
    out_item_t  r;
    longint     x;
    longint     y;
    longint     dx;
    longint     dy;
    longint     mag;
    logic [31:0] acc;
    logic [31:0] rounded;
    sw_alpha = next_switch(s.volt_alpha, s.amp_alpha, sw_alpha);
    sw_beta  = next_switch(s.volt_beta, s.amp_beta, sw_beta);
    emf_a    = filter_step(emf_a, sw_alpha);
    emf_b    = filter_step(emf_b, sw_beta);
    x = longint'(emf_b) * 256;
    y = -longint'(emf_a) * 256;
    r.rotor_angle   = '0;
    r.emf_magnitude = '0;
    if (x != 0 || y != 0) begin
      acc = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = HALF_TURN;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          acc += atan_turn(K_W'(k));
        end else begin
          x -= dx;
          y += dy;
          acc -= atan_turn(K_W'(k));
        end
      end
      rounded = acc + 32'h8000;
      r.rotor_angle = rounded[31:16];
      mag = (x * 652032874 + (longint'(1) << 37)) >>> 38;
      if (mag < 0) mag = 0;
      if (mag > 65535) mag = 65535;
      r.emf_magnitude = mag[15:0];
    end
    r.emf_alpha = emf_a;
    r.emf_beta  = emf_b;
    return r;
  endfunction

  function automatic in_item_t mk_sample(int va, int vb, int ia, int ib);
    in_item_t s;
    s.volt_alpha = 16'(va);
    s.volt_beta  = 16'(vb);
    s.amp_alpha  = 16'(ia);
    s.amp_beta   = 16'(ib);
    return s;
  endfunction

  function automatic in_item_t rand_sample();
    int g;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return mk_sample($urandom, $urandom, $urandom, $urandom);
    if (pick < 9) begin
      g = $urandom_range(0, 1) ? int'(slide_mag) : -int'(slide_mag);
      return mk_sample(g + $urandom_range(0, 2) - 1, -g + $urandom_range(0, 2) - 1,
                       $urandom_range(0, 1) ? 0 : $urandom_range(0, 3) - 1,
                       $urandom_range(0, 1) ? 0 : $urandom);
    end
    return mk_sample($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                     $urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32);
  endfunction

  function automatic logic [15:0] pick_cfg();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || emf_expect_q.size() != 0);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_STATOR_RES:  rs_ohm      = val;
      REG_SLIDE_GAIN:  slide_mag   = val[14:0];
      REG_FILTER_GAIN: lp_gain     = val;
      REG_CTRL_PERIOD: ctrl_period = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (in_valid && in_ready) emf_expect_q.push_back(advance_observer(in_data));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap  <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_src && $urandom_range(0, 7) == 0) begin
          src_gap  <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      sink_hold  <= LONG_HOLD;
      out_ready  <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_sink && $urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (emf_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: angle %0d mag %0d alpha %0d beta %0d",
                   out_data.rotor_angle, out_data.emf_magnitude,
                   out_data.emf_alpha, out_data.emf_beta);
      end else begin
        want = emf_expect_q.pop_front();
        if (out_data.rotor_angle !== want.rotor_angle
            || out_data.emf_magnitude !== want.emf_magnitude
            || out_data.emf_alpha !== want.emf_alpha
            || out_data.emf_beta !== want.emf_beta) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle %0d/%0d mag %0d/%0d alpha %0d/%0d beta %0d/%0d",
                     want.rotor_angle, out_data.rotor_angle,
                     want.emf_magnitude, out_data.emf_magnitude,
                     want.emf_alpha, out_data.emf_alpha,
                     want.emf_beta, out_data.emf_beta);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    idle_src  = 1'b1;
    idle_sink = 1'b1;

    sample_q.push_back(mk_sample(-32768, -32768, -32768, -32768));
    sample_q.push_back(mk_sample(32767, 32767, 32767, 32767));
    sample_q.push_back(mk_sample(0, 0, 0, 0));
    sample_q.push_back(mk_sample(32767, -32768, -32768, 32767));
    wait_drained();

    write_reg(REG_STATOR_RES, 16'hFFFF);
    write_reg(REG_SLIDE_GAIN, 16'h7FFF);
    write_reg(REG_FILTER_GAIN, 16'hFFFF);
    write_reg(REG_CTRL_PERIOD, 16'hFFFF);
    end_writes();
    sample_q.push_back(mk_sample(32767, 32767, 32767, 32767));
    sample_q.push_back(mk_sample(-32768, -32768, -32768, -32768));
    sample_q.push_back(mk_sample(32767, -32768, -32768, 32767));
    sample_q.push_back(mk_sample(-32768, 32767, 32767, -32768));
    sample_q.push_back(mk_sample(0, 0, 0, 0));
    sample_q.push_back(mk_sample(100, -100, 0, 0));
    wait_drained();
    // residual exactly zero, then just below zero on alpha only
    sample_q.push_back(mk_sample(sw_alpha, sw_beta, 0, 0));
    wait_drained();
    sample_q.push_back(mk_sample(sw_alpha, sw_beta, 1, -1));
    wait_drained();

    write_reg(REG_CTRL_PERIOD, 16'h0000);
    end_writes();
    sample_q.push_back(mk_sample(-32768, -32768, 32767, 32767));
    sample_q.push_back(mk_sample(32767, 32767, -32768, -32768));
    sample_q.push_back(mk_sample(-5, 7, 0, 0));
    wait_drained();

    for (int a = 4; a < 16; a++) write_reg(ADDR_W'(a), 16'($urandom));
    write_reg(REG_SLIDE_GAIN, 16'h8005);
    write_reg(REG_STATOR_RES, 16'h0000);
    write_reg(REG_FILTER_GAIN, 16'h0001);
    write_reg(REG_CTRL_PERIOD, 16'h0001);
    end_writes();
    sample_q.push_back(mk_sample(-32768, 32767, -32768, 32767));
    sample_q.push_back(mk_sample(5, -5, 32767, -32768));
    sample_q.push_back(mk_sample(-6, 4, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_STATOR_RES, pick_cfg());
      write_reg(REG_SLIDE_GAIN, pick_cfg());
      write_reg(REG_FILTER_GAIN, pick_cfg());
      write_reg(REG_CTRL_PERIOD, $urandom_range(0, 4) == 0 ? 16'h0000 : pick_cfg() | 16'h0001);
      end_writes();
      idle_src  = (ph < 9) && ($urandom_range(0, 3) != 0);
      idle_sink = (ph < 9) && ($urandom_range(0, 3) != 0);
      for (int j = 0; j < 165; j++) begin
        if (ph == 3 && j == 80) wait_drained();
        sample_q.push_back(rand_sample());
      end
      if (ph == 1) stall_reqs++;
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && emf_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/smo_pkg.sv
hw/rtl/smo_cordic_step.sv
hw/rtl/sliding_mode_backemf_observer_top.sv
dv/tb_top.sv
